// ===== rtl/core/agr_pkg.sv =====
package agr_pkg;

   // Field widths.
   localparam int SampleWidth   = 11;
   localparam int AdjWidth      = 12;
   localparam int IndexWidth    = 3;
   localparam int FactorWidth   = 5;
   localparam int CsrIndexWidth = 2;

   // Gain index limits and reset values.
   localparam logic [IndexWidth-1:0]  GainIndexMin   = 3'd1;
   localparam logic [IndexWidth-1:0]  GainIndexMax   = 3'd4;
   localparam logic [IndexWidth-1:0]  GainIndexReset = 3'd3;
   localparam logic [SampleWidth-1:0] UpperThresholdReset = 11'd430;
   localparam logic [SampleWidth-1:0] LowerThresholdReset = 11'd185;

   typedef enum logic [1:0] {
      VERDICT_OK   = 2'd0,
      VERDICT_LOW  = 2'd1,
      VERDICT_HIGH = 2'd2
   } verdict_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CALIBRATION_MODE = 2'd0,
      CSR_REFERENCE_LEVEL  = 2'd1,
      CSR_UPPER_THRESHOLD  = 2'd2,
      CSR_LOWER_THRESHOLD  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                   calibration_mode;
      logic [SampleWidth-1:0] reference_level;
      logic [SampleWidth-1:0] upper_threshold;
      logic [SampleWidth-1:0] lower_threshold;
   } csr_type;

   typedef struct packed {
      logic [IndexWidth-1:0]      gain_index;
      logic signed [AdjWidth-1:0] frame_peak;
      logic                       frame_aborted;
      logic                       frame_started;
      logic [SampleWidth-1:0]     latched_reference;
   } frame_state_type;

   typedef struct packed {
      logic signed [AdjWidth-1:0] adjusted_sample;
      logic                       sample_valid;
      logic                       verdict_valid;
      verdict_type                verdict;
      logic [IndexWidth-1:0]      gain_index;
      logic [FactorWidth-1:0]     gain_factor;
   } result_type;

   // Amplifier gain for a table index; indexes past the table saturate.
   function automatic logic [FactorWidth-1:0] gain_factor_of(
      input logic [IndexWidth-1:0] idx
   );
      logic [FactorWidth-1:0] factor;
      case (idx)
         3'd0:    factor = 5'd1;
         3'd1:    factor = 5'd2;
         3'd2:    factor = 5'd3;
         3'd3:    factor = 5'd5;
         3'd4:    factor = 5'd9;
         default: factor = 5'd17;
      endcase
      return factor;
   endfunction

endpackage

// ===== rtl/core/agr_frame_eval.sv =====
module agr_frame_eval
   import agr_pkg::*;
(
   input  csr_type                csr,
   input  frame_state_type        state,
   input  logic [SampleWidth-1:0] sample,
   input  logic [SampleWidth-1:0] measured_reference,
   input  logic                   last,
   output frame_state_type        state_next,
   output result_type             result
);

   logic [SampleWidth-1:0]     ref_level;
   logic signed [AdjWidth-1:0] adj;
   logic signed [AdjWidth-1:0] peak;
   logic signed [AdjWidth-1:0] peak_new;
   logic signed [AdjWidth-1:0] upper_s;
   logic signed [AdjWidth-1:0] lower_s;
   logic                       too_high;
   logic                       too_low;

   // The reference of calibration mode comes from the first item of the frame.
   always_comb begin
      if (csr.calibration_mode) begin
         ref_level = state.frame_started ? state.latched_reference : measured_reference;
      end else begin
         ref_level = csr.reference_level;
      end
   end

   // Offset removal and the threshold compares.
   assign adj      = $signed({1'b0, sample}) - $signed({1'b0, ref_level});
   assign peak     = state.frame_peak;
   assign peak_new = (adj > peak) ? adj : peak;
   assign upper_s  = $signed({1'b0, csr.upper_threshold});
   assign lower_s  = $signed({1'b0, csr.lower_threshold});
   assign too_high = (adj > upper_s) && (state.gain_index > GainIndexMin);
   assign too_low  = (peak_new < lower_s) && (state.gain_index < GainIndexMax);

   // Frame state update and result of this item.
   always_comb begin
      state_next = state;
      state_next.frame_started = 1'b1;
      if (!state.frame_started) begin
         state_next.latched_reference = measured_reference;
      end

      result.adjusted_sample = adj;
      result.sample_valid    = 1'b0;
      result.verdict_valid   = 1'b0;
      result.verdict         = VERDICT_OK;

      if (!state.frame_aborted) begin
         if (too_high) begin
            // Gain too high: step down and drop the rest of the frame.
            state_next.gain_index    = state.gain_index - 3'd1;
            state_next.frame_aborted = 1'b1;
            result.verdict_valid     = 1'b1;
            result.verdict           = VERDICT_HIGH;
         end else begin
            result.sample_valid   = 1'b1;
            state_next.frame_peak = peak_new;
            if (last) begin
               result.verdict_valid = 1'b1;
               if (too_low) begin
                  state_next.gain_index = state.gain_index + 3'd1;
                  result.verdict        = VERDICT_LOW;
               end
            end
         end
      end

      // The last item closes the frame.
      if (last) begin
         state_next.frame_started = 1'b0;
         state_next.frame_aborted = 1'b0;
         state_next.frame_peak    = '0;
      end

      result.gain_index  = state_next.gain_index;
      result.gain_factor = gain_factor_of(state_next.gain_index);
   end

endmodule

// ===== rtl/core/adc_auto_gain_ranging.sv =====
// Automatic gain ranging for a current-sense ADC front end.
// Input channel (req_*): one 11-bit sample per item with its reference reading
// and a last marker that closes the frame. Result channel (rsp_*): one item per
// input item, carrying the offset-corrected sample, its keep flag, the frame's
// gain verdict when decided, and the gain index and factor after that item.
// Configuration (csr_*): a plain write port for mode, reference level and the
// two thresholds; the user must write it only while no item is in flight, which
// the block does not enforce. An item accepted at a clock edge is registered and
// offered on rsp_* right after that edge, one item per cycle while the receiver
// takes results; the subtract, the compares and the state update all sit between
// the accept edge and the result register. req_ready is high while the result
// register is empty or being taken, so a stalled receiver holds the result and
// stops input after that one item. Reset clears the frame state, sets the gain
// index to 3, loads the default thresholds and empties the result register.
module adc_auto_gain_ranging
   import agr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SampleWidth-1:0]     req_sample,
   input  logic [SampleWidth-1:0]     req_measured_reference,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [AdjWidth-1:0] rsp_adjusted_sample,
   output logic                       rsp_sample_valid,
   output logic                       rsp_verdict_valid,
   output logic [1:0]                 rsp_verdict,
   output logic [IndexWidth-1:0]      rsp_gain_index_out,
   output logic [FactorWidth-1:0]     rsp_gain_factor,
   input  logic                       csr_write,
   input  logic [CsrIndexWidth-1:0]   csr_index,
   input  logic [SampleWidth-1:0]     csr_wdata
);

   csr_type         csr_ff;
   frame_state_type state_ff;
   frame_state_type state_in;
   result_type      rsp_ff;
   result_type      rsp_in;
   logic            rsp_valid_ff;
   logic            accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.calibration_mode <= 1'b0;
         csr_ff.reference_level  <= '0;
         csr_ff.upper_threshold  <= UpperThresholdReset;
         csr_ff.lower_threshold  <= LowerThresholdReset;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CALIBRATION_MODE: csr_ff.calibration_mode <= csr_wdata[0];
            CSR_REFERENCE_LEVEL:  csr_ff.reference_level  <= csr_wdata;
            CSR_UPPER_THRESHOLD:  csr_ff.upper_threshold  <= csr_wdata;
            CSR_LOWER_THRESHOLD:  csr_ff.lower_threshold  <= csr_wdata;
            default:              csr_ff <= csr_ff;
         endcase
      end
   end

   // Take an item whenever the result register is free or being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   agr_frame_eval u_eval (
      .csr                (csr_ff),
      .state              (state_ff),
      .sample             (req_sample),
      .measured_reference (req_measured_reference),
      .last               (req_last),
      .state_next         (state_in),
      .result             (rsp_in)
   );

   // Frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.gain_index        <= GainIndexReset;
         state_ff.frame_peak        <= '0;
         state_ff.frame_aborted     <= 1'b0;
         state_ff.frame_started     <= 1'b0;
         state_ff.latched_reference <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_adjusted_sample = rsp_ff.adjusted_sample;
   assign rsp_sample_valid    = rsp_ff.sample_valid;
   assign rsp_verdict_valid   = rsp_ff.verdict_valid;
   assign rsp_verdict         = rsp_ff.verdict;
   assign rsp_gain_index_out  = rsp_ff.gain_index;
   assign rsp_gain_factor     = rsp_ff.gain_factor;

endmodule

// ===== rtl/core/agr_checker.sv =====
module agr_checker
   import agr_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [AdjWidth-1:0] rsp_adjusted_sample,
   input logic                       rsp_sample_valid,
   input logic                       rsp_verdict_valid,
   input logic [1:0]                 rsp_verdict,
   input logic [IndexWidth-1:0]      rsp_gain_index_out
);

   // A result that is not taken stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_adjusted_sample))
      else $error("stalled result item changed or vanished");

   // The result register is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item offered right after reset");

   // A too-high verdict drops its sample; no verdict means the ok code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict_valid || rsp_verdict == VERDICT_OK) &&
                    (rsp_verdict != VERDICT_HIGH || !rsp_sample_valid))
      else $error("verdict inconsistent with its flags");

   // The gain index stays within its stepping range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_index_out >= GainIndexMin &&
                    rsp_gain_index_out <= GainIndexMax)
      else $error("gain index left its range");

endmodule

bind adc_auto_gain_ranging agr_checker u_agr_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_adjusted_sample (rsp_adjusted_sample),
   .rsp_sample_valid    (rsp_sample_valid),
   .rsp_verdict_valid   (rsp_verdict_valid),
   .rsp_verdict         (rsp_verdict),
   .rsp_gain_index_out  (rsp_gain_index_out)
);

// ===== test/adc_auto_gain_ranging_tb.sv =====
`timescale 1ns / 100ps

module adc_auto_gain_ranging_tb
   import agr_pkg::*;
();

   localparam int WatchdogLimit = 5000;
   localparam int PhaseItems    = 230;
   localparam int PhaseCount    = 8;

   // Tracks the gain ranging state and holds the results expected from the block.
   class gain_scoreboard;
      csr_type                    cfg;
      logic [IndexWidth-1:0]      gain_idx;
      int                         peak;
      bit                         aborted;
      bit                         started;
      logic [SampleWidth-1:0]     latched;
      int unsigned                gain_steps[6];
      result_type                 ranged_samples[$];
      int                         failures;

      function new();
         cfg.calibration_mode = 1'b0;
         cfg.reference_level  = '0;
         cfg.upper_threshold  = 11'd430;
         cfg.lower_threshold  = 11'd185;
         gain_idx   = 3'd3;
         peak       = 0;
         aborted    = 1'b0;
         started    = 1'b0;
         latched    = '0;
         gain_steps = '{1, 2, 3, 5, 9, 17};
         failures   = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [SampleWidth-1:0] value);
         case (idx)
            CSR_CALIBRATION_MODE: cfg.calibration_mode = value[0];
            CSR_REFERENCE_LEVEL:  cfg.reference_level  = value;
            CSR_UPPER_THRESHOLD:  cfg.upper_threshold  = value;
            CSR_LOWER_THRESHOLD:  cfg.lower_threshold  = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return ranged_samples.size();
      endfunction

      // Works out the result of one accepted sample and queues it.
      function void note_sample(logic [SampleWidth-1:0] smp, logic [SampleWidth-1:0] meas,
                                logic is_last);
         result_type want;
         int         offset;
         int         adj;
         want = '0;
         if (!started) begin
            latched = meas;
            started = 1'b1;
         end
         offset = cfg.calibration_mode ? int'(latched) : int'(cfg.reference_level);
         adj = int'(smp) - offset;
         want.verdict = VERDICT_OK;
         if (!aborted) begin
            if (adj > int'(cfg.upper_threshold) && gain_idx > GainIndexMin) begin
               // Gain too high: the rest of this frame is thrown away.
               gain_idx = gain_idx - 1'b1;
               aborted = 1'b1;
               want.verdict_valid = 1'b1;
               want.verdict = VERDICT_HIGH;
            end else begin
               want.sample_valid = 1'b1;
               if (adj > peak) peak = adj;
               if (is_last) begin
                  want.verdict_valid = 1'b1;
                  if (peak < int'(cfg.lower_threshold) && gain_idx < GainIndexMax) begin
                     gain_idx = gain_idx + 1'b1;
                     want.verdict = VERDICT_LOW;
                  end
               end
            end
         end
         if (is_last) begin
            started = 1'b0;
            aborted = 1'b0;
            peak = 0;
         end
         want.adjusted_sample = AdjWidth'(adj);
         want.gain_index = gain_idx;
         want.gain_factor = FactorWidth'(gain_steps[(gain_idx > 3'd5) ? 5 : gain_idx]);
         ranged_samples.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Compares one result item with the oldest expectation.
      function void check_ranged(result_type got);
         result_type want;
         if (ranged_samples.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual adjusted_sample %0d",
                     $time, got.adjusted_sample);
            return;
         end
         want = ranged_samples.pop_front();
         compare_field("adjusted_sample", int'(want.adjusted_sample), int'(got.adjusted_sample));
         compare_field("sample_valid", want.sample_valid, got.sample_valid);
         compare_field("verdict_valid", want.verdict_valid, got.verdict_valid);
         compare_field("verdict", int'(want.verdict), int'(got.verdict));
         compare_field("gain_index_out", want.gain_index, got.gain_index);
         compare_field("gain_factor", want.gain_factor, got.gain_factor);
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [SampleWidth-1:0]     req_sample = '0;
   logic [SampleWidth-1:0]     req_measured_reference = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [AdjWidth-1:0] rsp_adjusted_sample;
   logic                       rsp_sample_valid;
   logic                       rsp_verdict_valid;
   logic [1:0]                 rsp_verdict;
   logic [IndexWidth-1:0]      rsp_gain_index_out;
   logic [FactorWidth-1:0]     rsp_gain_factor;
   logic                       csr_write = 1'b0;
   logic [CsrIndexWidth-1:0]   csr_index = '0;
   logic [SampleWidth-1:0]     csr_wdata = '0;

   gain_scoreboard sb;
   result_type     seen;
   bit             tx_steady = 1'b0;
   bit             rx_steady = 1'b0;
   int             rx_stall = 0;
   int             idle_cycles = 0;
   int             items_sent = 0;

   adc_auto_gain_ranging u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_sample             (req_sample),
      .req_measured_reference (req_measured_reference),
      .req_last               (req_last),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_adjusted_sample    (rsp_adjusted_sample),
      .rsp_sample_valid       (rsp_sample_valid),
      .rsp_verdict_valid      (rsp_verdict_valid),
      .rsp_verdict            (rsp_verdict),
      .rsp_gain_index_out     (rsp_gain_index_out),
      .rsp_gain_factor        (rsp_gain_factor),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length: mostly none, often short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver side: random stalls unless a steady stretch is running.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_stall != 0) begin
         rx_stall = rx_stall - 1;
         rsp_ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
         rx_stall = idle_length();
         rsp_ready <= (rx_stall == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Both channels are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.adjusted_sample = rsp_adjusted_sample;
            seen.sample_valid    = rsp_sample_valid;
            seen.verdict_valid   = rsp_verdict_valid;
            seen.verdict         = verdict_type'(rsp_verdict);
            seen.gain_index      = rsp_gain_index_out;
            seen.gain_factor     = rsp_gain_factor;
            sb.check_ranged(seen);
         end
         if (req_valid && req_ready)
            sb.note_sample(req_sample, req_measured_reference, req_last);
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one item from a falling edge and returns at the falling edge after acceptance.
   task automatic send_item(logic [SampleWidth-1:0] smp, logic [SampleWidth-1:0] meas,
                            logic is_last);
      int gap;
      gap = tx_steady ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= smp;
      req_measured_reference <= meas;
      req_last <= is_last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Stops input and waits until every result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (2) @(negedge clock);
   endtask

   // Writes all four registers on consecutive cycles; the block must be idle.
   task automatic write_config(logic mode, logic [SampleWidth-1:0] level,
                               logic [SampleWidth-1:0] upper, logic [SampleWidth-1:0] lower);
      logic [SampleWidth-1:0] values[4];
      values = '{{10'd0, mode}, level, upper, lower};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= CsrIndexWidth'(i);
         csr_wdata <= values[i];
         sb.set_register(csr_index_type'(i), values[i]);
         @(negedge clock);
      end
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SampleWidth-1:0] clamp_sample(int v);
      if (v < 0) return '0;
      if (v > 2047) return 11'd2047;
      return SampleWidth'(v);
   endfunction

   // Samples are spread uniformly or placed near the offset and the two thresholds.
   function automatic logic [SampleWidth-1:0] pick_sample(int offset);
      case ($urandom_range(0, 3))
         0: return SampleWidth'($urandom_range(0, 2047));
         1: return clamp_sample(offset + $urandom_range(0, 600) - 300);
         2: return clamp_sample(offset + int'(sb.cfg.upper_threshold) + $urandom_range(0, 6) - 3);
         default: return clamp_sample(offset + int'(sb.cfg.lower_threshold)
                                      + $urandom_range(0, 6) - 3);
      endcase
   endfunction

   function automatic logic [SampleWidth-1:0] pick_register();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 11'd2047;
         default: return SampleWidth'($urandom_range(0, 2047));
      endcase
   endfunction

   // One random-length frame; in calibration mode its first reference reading is the offset.
   task automatic random_frame();
      int                     len;
      int                     r;
      int                     offset;
      logic [SampleWidth-1:0] meas0;
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 85) len = $urandom_range(2, 16);
      else len = $urandom_range(17, 40);
      meas0 = SampleWidth'($urandom_range(0, 2047));
      offset = sb.cfg.calibration_mode ? int'(meas0) : int'(sb.cfg.reference_level);
      for (int k = 0; k < len; k++)
         send_item(pick_sample(offset), (k == 0) ? meas0 : SampleWidth'($urandom_range(0, 2047)),
                   k == len - 1);
   endtask

   task automatic directed_items();
      // Reset values: the index climbs to its top and then holds.
      send_item(11'd0, 11'd0, 1'b1);
      send_item(11'd0, 11'd0, 1'b1);
      // Early end, then the rest of the frame is not kept.
      send_item(11'd2047, 11'd2047, 1'b0);
      send_item(11'd100, 11'd0, 1'b0);
      send_item(11'd2047, 11'd0, 1'b0);
      send_item(11'd0, 11'd0, 1'b1);
      // Early end on the last item, down to the bottom of the range and held there.
      send_item(11'd2047, 11'd0, 1'b1);
      send_item(11'd2047, 11'd0, 1'b1);
      send_item(11'd2047, 11'd0, 1'b1);
      // Threshold edges.
      send_item(11'd200, 11'd0, 1'b0);
      send_item(11'd186, 11'd0, 1'b1);
      send_item(11'd184, 11'd0, 1'b1);
      send_item(11'd430, 11'd0, 1'b1);
      send_item(11'd431, 11'd0, 1'b1);
      // Largest offset with extreme thresholds.
      settle();
      write_config(1'b0, 11'd2047, 11'd0, 11'd2047);
      send_item(11'd0, 11'd0, 1'b1);
      send_item(11'd2047, 11'd2047, 1'b1);
      // Mode change inside a frame uses the reading latched on its first item.
      settle();
      write_config(1'b0, 11'd0, 11'd2047, 11'd0);
      send_item(11'd1000, 11'd1500, 1'b0);
      settle();
      write_config(1'b1, 11'd0, 11'd2047, 11'd0);
      send_item(11'd1500, 11'd0, 1'b1);
      // Calibration mode at both ends of the reference reading.
      send_item(11'd0, 11'd2047, 1'b1);
      send_item(11'd2047, 11'd0, 1'b1);
      send_item(11'd2047, 11'd0, 1'b1);
      settle();
      write_config(1'b1, 11'd2047, 11'd0, 11'd0);
      send_item(11'd2047, 11'd0, 1'b0);
      send_item(11'd5, 11'd2047, 1'b1);
   endtask

   initial begin
      int                     start;
      logic [SampleWidth-1:0] upper;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_items();

      // Random phases, each with its own register setting and idling style.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            write_config(1'b0, 11'd0, 11'd430, 11'd185);
         end else if (phase == 1) begin
            write_config(1'b1, 11'd2047, 11'd2047, 11'd2047);
         end else if (phase == 2) begin
            write_config(1'b0, 11'd2047, 11'd0, 11'd0);
         end else begin
            upper = ($urandom_range(0, 3) == 0) ? pick_register()
                                                 : SampleWidth'($urandom_range(100, 1200));
            write_config(1'($urandom_range(0, 1)), pick_register(), upper,
                         ($urandom_range(0, 3) == 0) ? pick_register()
                                                      : SampleWidth'($urandom_range(0, upper)));
         end
         start = items_sent;
         while (items_sent - start < PhaseItems)
            random_frame();
      end

      // Drain the last results and allow a few more cycles for strays.
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
